// ===== rtl/pctm_pkg.sv =====
// ----------------------------------------------------------------------------
// pctm_pkg
// Shared types, register codes and small arithmetic helpers of the pilot
// command tier mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package pctm_pkg;

	localparam int AXIS_W = 16;
	localparam int SUM_W  = 19;
	localparam int TIER_W = 8;
	localparam int CNT_W  = 4;
	localparam int THR_W  = 16;
	localparam int MAG_W  = 19;
	localparam int PROD_W = 51;

	// Register codes, from paddr[3:2]
	localparam logic [1:0] REG_INVERT = 2'd0;
	localparam logic [1:0] REG_MODE   = 2'd1;
	localparam logic [1:0] REG_RAMP   = 2'd2;
	localparam logic [1:0] REG_START  = 2'd3;

	localparam logic [15:0] RAMP_RESET = 16'd256;

	localparam logic signed [SUM_W-1:0] AXIS_MAX_S = 19'sd32767;
	localparam logic signed [SUM_W-1:0] AXIS_MIN_S = -19'sd32767;

	// One command source
	typedef struct packed {
		logic                      active;
		logic signed [TIER_W-1:0]  prio;
		logic signed [AXIS_W-1:0]  roll;
		logic signed [AXIS_W-1:0]  pitch;
		logic signed [AXIS_W-1:0]  yaw;
		logic signed [AXIS_W-1:0]  rate;
		logic                      has_abs;
		logic [THR_W-1:0]          abs_val;
	} pctm_item_t;

	// Running state of the winning tier
	typedef struct packed {
		logic                      tier_seen;
		logic signed [TIER_W-1:0]  best_tier;
		logic signed [SUM_W-1:0]   roll_sum;
		logic signed [SUM_W-1:0]   pitch_sum;
		logic signed [SUM_W-1:0]   yaw_sum;
		logic signed [SUM_W-1:0]   rate_sum;
		logic                      abs_flag;
		logic [THR_W-1:0]          abs_val;
		logic [CNT_W-1:0]          count;
	} pctm_tier_t;

	// Saturating add of one axis sample into a running sum
	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0]  s,
		input logic signed [AXIS_W-1:0] v
	);
		logic signed [SUM_W:0] t;
		t = {s[SUM_W-1], s} + {{(SUM_W+1-AXIS_W){v[AXIS_W-1]}}, v};
		if (t[SUM_W] != t[SUM_W-1]) begin
			sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sat_add = t[SUM_W-1:0];
		end
	endfunction

	// Clamp a running sum to the symmetric unit range
	function automatic logic signed [AXIS_W-1:0] clamp_axis(
		input logic signed [SUM_W-1:0] s
	);
		if (s > AXIS_MAX_S) begin
			clamp_axis = AXIS_MAX_S[AXIS_W-1:0];
		end else if (s < AXIS_MIN_S) begin
			clamp_axis = AXIS_MIN_S[AXIS_W-1:0];
		end else begin
			clamp_axis = s[AXIS_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pctm_accum.sv =====
// ----------------------------------------------------------------------------
// pctm_accum
// Tier accumulator: tracks the highest active tier and sums its sources.
// Exposes the state as it stands after the item on the input.
// ----------------------------------------------------------------------------
`default_nettype none

module pctm_accum
	import pctm_pkg::*;
#(
	parameter int MAX_SOURCES = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        accept,
	input  wire        last,
	input  wire pctm_item_t item,
	output pctm_tier_t tier_nxt
);

	localparam int CAP_I = (MAX_SOURCES > 15) ? 15 : MAX_SOURCES;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_I);

	pctm_tier_t tier_q;
	pctm_tier_t base;
	logic       restart;
	logic       take;

	// Restart on a higher tier, then mix if the tier still has room
	always_comb begin
		restart = item.active && (!tier_q.tier_seen || (item.prio > tier_q.best_tier));
		base = tier_q;
		if (restart) begin
			base           = '0;
			base.tier_seen = 1'b1;
			base.best_tier = item.prio;
		end
		take = item.active && (item.prio == base.best_tier) && (base.count < CAP);
		tier_nxt = base;
		if (take) begin
			tier_nxt.roll_sum  = sat_add(base.roll_sum, item.roll);
			tier_nxt.pitch_sum = sat_add(base.pitch_sum, item.pitch);
			tier_nxt.yaw_sum   = sat_add(base.yaw_sum, item.yaw);
			tier_nxt.rate_sum  = sat_add(base.rate_sum, item.rate);
			tier_nxt.count     = base.count + 1'b1;
			if (item.has_abs) begin
				tier_nxt.abs_flag = 1'b1;
				tier_nxt.abs_val  = item.abs_val;
			end
		end
	end

	// Advance on each transfer; drop the tier once the tick closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tier_q <= '0;
		end else if (accept) begin
			tier_q <= last ? '0 : tier_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pctm_ramp_mul.sv =====
// ----------------------------------------------------------------------------
// pctm_ramp_mul
// Bit-serial shift-add multiplier for the throttle ramp step. First pass
// forms ramp_rate * tick_dt, second pass multiplies that by the rate magnitude.
// One multiplier bit per cycle, over the 19 multiplier bits of each pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pctm_ramp_mul
	import pctm_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire  [15:0]       ramp_rate,
	input  wire  [15:0]       tick_dt,
	input  wire  [MAG_W-1:0]  mag,
	output logic              busy,
	output logic [PROD_W-1:0] product
);

	localparam int STEPS = MAG_W;
	localparam int CW    = $clog2(STEPS);
	localparam int MW    = PROD_W - MAG_W;

	logic          busy_q;
	logic          phase_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] mcand_q;
	logic [MW-1:0] hi_q;
	logic [MAG_W-1:0] lo_q;
	logic [MAG_W-1:0] mag_q;
	logic [MW:0]   sum;
	logic [PROD_W-1:0] prod_next;
	logic          last_step;

	// One partial product per cycle, shifted out at the low end
	assign sum       = {1'b0, hi_q} + {1'b0, (lo_q[0] ? mcand_q : {MW{1'b0}})};
	assign prod_next = {sum, lo_q[MAG_W-1:1]};
	assign last_step = (cnt_q == CW'(STEPS - 1));

	// Sequence the two passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (busy_q) begin
			if (last_step) begin
				cnt_q <= '0;
				if (!phase_q) begin
					phase_q <= 1'b1;
				end else begin
					busy_q <= 1'b0;
				end
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Shift the datapath
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= MW'(ramp_rate);
			hi_q    <= '0;
			lo_q    <= MAG_W'(tick_dt);
			mag_q   <= mag;
		end else if (busy_q) begin
			if (last_step && !phase_q) begin
				mcand_q <= prod_next[MW-1:0];
				hi_q    <= '0;
				lo_q    <= mag_q;
			end else begin
				hi_q <= sum[MW:1];
				lo_q <= {sum[0], lo_q[MAG_W-1:1]};
			end
		end
	end

	assign busy    = busy_q;
	assign product = {hi_q, lo_q};

endmodule

`default_nettype wire

// ===== rtl/pilot_command_tier_mixer_core.sv =====
// ----------------------------------------------------------------------------
// pilot_command_tier_mixer_core
// Priority-tier mixer of pilot command sources: sums the highest active tier,
// clamps the axes and sets the throttle at the end of each tick.
// ----------------------------------------------------------------------------
// Flow: a source that does not close the tick is taken and the next may be
// taken in the following cycle. A closing source goes to the done state with
// an absolute or stick throttle, else through the rate ramp, two 19-step
// passes of the bit-serial multiplier; the result then loads into the output
// register once it is free, and no source is taken until it is loaded there.
// Reset clears the tier, sets ramp_rate to 256 and throttle to start_throttle 0.
`default_nettype none

module pilot_command_tier_mixer_core
	import pctm_pkg::*;
#(
	parameter int MAX_SOURCES = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	// source stream
	input  wire          s_tvalid,
	output logic         s_tready,
	// priority_req[7:0], roll_in[23:8], pitch_in[39:24], yaw_in[55:40],
	// throttle_rate_in[71:56], abs_throttle_in[87:72], tick_dt[103:88]
	input  wire  [103:0] s_tdata,
	// source_active[0], has_abs_throttle[1]
	input  wire  [1:0]   s_tuser,
	input  wire          s_tlast,
	// result stream
	output logic         m_tvalid,
	input  wire          m_tready,
	// roll_cmd[15:0], right_aileron[31:16], pitch_cmd[47:32], yaw_cmd[63:48],
	// throttle_out[79:64], winning_tier[87:80], active_count[91:88], zero[95:92]
	output logic [95:0]  m_tdata,
	// configuration
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [3:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int CAP_I = (MAX_SOURCES > 15) ? 15 : MAX_SOURCES;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_I);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]  state_q;

	// configuration registers
	logic        invert_q;
	logic        mode_q;
	logic [15:0] ramp_q;
	logic [15:0] start_q;
	logic [THR_W-1:0] level_q;
	logic        cfg_wr;
	logic [1:0]  reg_sel;

	// source side
	pctm_item_t  item;
	pctm_tier_t  tier_nxt;
	logic        in_xfer;
	logic        close_xfer;

	// closing snapshot
	logic signed [AXIS_W-1:0] roll_q, pitch_q, yaw_q;
	logic signed [TIER_W-1:0] tier_q;
	logic [CNT_W-1:0]         count_q;
	logic                     abs_flag_q;
	logic [THR_W-1:0]         abs_val_q;
	logic signed [SUM_W-1:0]  rate_q;
	logic                     use_stick_q;

	logic signed [AXIS_W-1:0] pitch_c;
	logic                     invert_c;
	logic [MAG_W-1:0]         mag_c;
	logic                     direct_c;

	// multiplier
	logic                     mul_start;
	logic                     mul_busy;
	logic [PROD_W-1:0]        product;

	// throttle and output
	logic signed [SUM_W:0]    stick_sum;
	logic [THR_W-1:0]         stick_thr;
	logic [28:0]              step;
	logic signed [30:0]       ramp_sum;
	logic [THR_W-1:0]         ramp_thr;
	logic [THR_W-1:0]         thr_c;
	logic                     out_load;
	logic                     m_tvalid_q;
	logic [95:0]              m_tdata_q;

	// Unpack the source transfer
	assign item.active  = s_tuser[0];
	assign item.prio    = s_tdata[7:0];
	assign item.roll    = s_tdata[23:8];
	assign item.pitch   = s_tdata[39:24];
	assign item.yaw     = s_tdata[55:40];
	assign item.rate    = s_tdata[71:56];
	assign item.has_abs = s_tuser[1];
	assign item.abs_val = s_tdata[87:72];

	assign s_tready   = (state_q == ST_IDLE);
	assign in_xfer    = s_tvalid && s_tready;
	assign close_xfer = in_xfer && s_tlast;

	pctm_accum #(
		.MAX_SOURCES(MAX_SOURCES)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_xfer),
		.last     (s_tlast),
		.item     (item),
		.tier_nxt (tier_nxt)
	);

	// Configuration writes and reads
	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			REG_INVERT: prdata = {31'b0, invert_q};
			REG_MODE:   prdata = {31'b0, mode_q};
			REG_RAMP:   prdata = {16'b0, ramp_q};
			REG_START:  prdata = {16'b0, start_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
			mode_q   <= 1'b0;
			ramp_q   <= RAMP_RESET;
			start_q  <= '0;
			level_q  <= '0;
		end else begin
			if (cfg_wr) begin
				case (reg_sel)
					REG_INVERT: invert_q <= pwdata[0];
					REG_MODE:   mode_q   <= pwdata[0];
					REG_RAMP:   ramp_q   <= pwdata[15:0];
					REG_START: begin
						start_q <= pwdata[15:0];
						level_q <= pwdata[15:0];
					end
					default: ;
				endcase
			end else if (out_load) begin
				level_q <= thr_c;
			end
		end
	end

	// Clamp the closing tier and pick the throttle path
	always_comb begin
		invert_c = invert_q && tier_nxt.tier_seen && (tier_nxt.best_tier == '0);
		pitch_c  = clamp_axis(tier_nxt.pitch_sum);
		if (invert_c) begin
			pitch_c = -pitch_c;
		end
		mag_c    = tier_nxt.rate_sum[SUM_W-1] ? MAG_W'(-tier_nxt.rate_sum)
		                                      : MAG_W'(tier_nxt.rate_sum);
		direct_c = tier_nxt.abs_flag || mode_q;
	end

	assign mul_start = close_xfer && !direct_c;

	// Hold the snapshot of the closing tick
	always_ff @(posedge clk) begin
		if (close_xfer) begin
			roll_q      <= clamp_axis(tier_nxt.roll_sum);
			pitch_q     <= pitch_c;
			yaw_q       <= clamp_axis(tier_nxt.yaw_sum);
			tier_q      <= tier_nxt.tier_seen ? tier_nxt.best_tier : '0;
			count_q     <= tier_nxt.count;
			abs_flag_q  <= tier_nxt.abs_flag;
			abs_val_q   <= tier_nxt.abs_val;
			rate_q      <= tier_nxt.rate_sum;
			use_stick_q <= mode_q;
		end
	end

	pctm_ramp_mul u_ramp_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mul_start),
		.ramp_rate (ramp_q),
		.tick_dt   (s_tdata[103:88]),
		.mag       (mag_c),
		.busy      (mul_busy),
		.product   (product)
	);

	// Throttle: absolute override, stick position or rounded ramp step
	always_comb begin
		stick_sum = {rate_q[SUM_W-1], rate_q} + (SUM_W+1)'(32768);
		if (stick_sum < 0) begin
			stick_thr = '0;
		end else if (stick_sum > (SUM_W+1)'(65535)) begin
			stick_thr = '1;
		end else begin
			stick_thr = stick_sum[THR_W-1:0];
		end

		step = {1'b0, product[PROD_W-1:23]} + 29'(product[22]);
		if (rate_q[SUM_W-1]) begin
			ramp_sum = 31'(level_q) - 31'(step);
		end else begin
			ramp_sum = 31'(level_q) + 31'(step);
		end
		if (ramp_sum < 0) begin
			ramp_thr = '0;
		end else if (ramp_sum > 31'sd65535) begin
			ramp_thr = '1;
		end else begin
			ramp_thr = ramp_sum[THR_W-1:0];
		end

		if (abs_flag_q) begin
			thr_c = abs_val_q;
		end else if (use_stick_q) begin
			thr_c = stick_thr;
		end else begin
			thr_c = ramp_thr;
		end
	end

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// Sequence one closing tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (close_xfer) begin
						state_q <= direct_c ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL: begin
					if (!mul_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {4'b0, count_q, tier_q, thr_c, yaw_q, pitch_q, -roll_q, roll_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Checks
	a_mul_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_busy |-> (state_q == ST_MUL))
		else $error("multiplier busy outside the ramp state");

	a_mul_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) && !mul_busy |=> (state_q == ST_DONE))
		else $error("ramp state not left when the multiplier finished");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && m_tvalid && !m_tready |=> (state_q == ST_DONE))
		else $error("pending result overwritten");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[91:88] <= CAP))
		else $error("active count beyond the tier capacity");

	a_tier_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[87:80] != 8'd0) |-> (m_tdata[91:88] != 4'd0))
		else $error("non-zero tier with no mixed source");

endmodule

`default_nettype wire
